@@ design/hrhp_pkg.sv @@
// ----------------------------------------------------------------------------
// hrhp_pkg: shared types and constants of the response head parser
// Phase encoding, byte region codes, character constants and the result
// record passed from the parsing core to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package hrhp_pkg;

   // default width of the header and body length counters
   localparam int LENGTH_BITS_DEFAULT = 16;

   // characters of interest
   localparam logic [7:0] CH_CR   = 8'h0D;
   localparam logic [7:0] CH_LF   = 8'h0A;
   localparam logic [7:0] CH_SP   = 8'h20;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_NUL  = 8'h00;

   // saturation value of the status code and of reported lengths
   localparam logic [15:0] FIELD_MAX = 16'hFFFF;

   // parser phase
   typedef enum logic [2:0] {
      PH_VERSION   = 3'd0,
      PH_CODE      = 3'd1,
      PH_LINE      = 3'd2,
      PH_HEAD      = 3'd3,
      PH_BODY      = 3'd4,
      PH_HALT_LINE = 3'd5,
      PH_HALT_HEAD = 3'd6
   } phase_type;

   // byte class
   typedef enum logic [1:0] {
      REGION_STATUS = 2'd0,
      REGION_HEADER = 2'd1,
      REGION_BODY   = 2'd2
   } region_type;

   // one result per byte
   typedef struct packed {
      region_type  region;
      logic        end_of_response;
      logic        boundary_found;
      logic [15:0] status_value;
      logic [15:0] header_length;
      logic [15:0] body_length;
   } result_type;

endpackage : hrhp_pkg

`default_nettype wire

@@ design/hrhp_core.sv @@
// ----------------------------------------------------------------------------
// hrhp_core: per-byte parsing step
// Holds the parser state and computes the next state and the result for the
// byte in the input register in one pass of short logic.
// ----------------------------------------------------------------------------
`default_nettype none

module hrhp_core #(
   parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      step_en,
   input  wire  [7:0]               data_byte,
   input  wire                      final_byte,
   output hrhp_pkg::result_type     result
);
   import hrhp_pkg::*;

   // state registers
   phase_type              phase_ff,  phase_in, phase_nx;
   logic [15:0]            status_ff, status_in, status_nx;
   logic [LENGTH_BITS-1:0] hcnt_ff,   hcnt_in,   hcnt_nx;
   logic [LENGTH_BITS-1:0] bcnt_ff,   bcnt_in,   bcnt_nx;
   logic [7:0]             recent_ff [3];
   logic [7:0]             recent_in [3];
   logic [7:0]             recent_nx [3];
   logic [1:0]             fill_ff,   fill_in,   fill_nx;

   logic                   is_digit;
   logic                   is_nul;
   logic                   blank_match;
   logic [19:0]            acc_wide;
   logic [19:0]            acc_prod;
   logic                   found;
   logic [15:0]            hlen16;
   logic [15:0]            blen16;

   // character classes and blank line match
   assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign is_nul      = (data_byte == CH_NUL);
   assign blank_match = (data_byte == CH_LF) &&
                        (((fill_ff != 2'd0) && (recent_ff[0] == CH_LF)) ||
                         ((fill_ff == 2'd3) && (recent_ff[0] == CH_CR) &&
                          (recent_ff[1] == CH_LF) && (recent_ff[2] == CH_CR)));

   // next phase
   always_comb begin
      phase_nx = phase_ff;
      unique case (phase_ff)
         PH_VERSION: begin
            if (data_byte == CH_SP) phase_nx = PH_CODE;
            else if (is_nul)        phase_nx = PH_HALT_LINE;
         end
         PH_CODE: begin
            if (is_digit)                 phase_nx = PH_CODE;
            else if (data_byte == CH_LF)  phase_nx = PH_HEAD;
            else if (is_nul)              phase_nx = PH_HALT_LINE;
            else                          phase_nx = PH_LINE;
         end
         PH_LINE: begin
            if (data_byte == CH_LF) phase_nx = PH_HEAD;
            else if (is_nul)        phase_nx = PH_HALT_LINE;
         end
         PH_HEAD: begin
            if (is_nul)           phase_nx = PH_HALT_HEAD;
            else if (blank_match) phase_nx = PH_BODY;
         end
         default: phase_nx = phase_ff;
      endcase
   end

   // status code accumulation, times ten by shift and add
   assign acc_wide = {4'd0, status_ff};
   assign acc_prod = (acc_wide << 3) + (acc_wide << 1) + {16'd0, data_byte[3:0]};

   // datapath updates
   always_comb begin
      status_nx    = status_ff;
      hcnt_nx      = hcnt_ff;
      bcnt_nx      = bcnt_ff;
      recent_nx[0] = recent_ff[0];
      recent_nx[1] = recent_ff[1];
      recent_nx[2] = recent_ff[2];
      fill_nx      = fill_ff;
      if ((phase_ff == PH_CODE) && is_digit) begin
         status_nx = (|acc_prod[19:16]) ? FIELD_MAX : acc_prod[15:0];
      end
      if (((phase_ff == PH_CODE) || (phase_ff == PH_LINE)) && (data_byte == CH_LF)) begin
         fill_nx = 2'd0;
      end
      if ((phase_ff == PH_HEAD) && !is_nul) begin
         if (!(&hcnt_ff)) hcnt_nx = hcnt_ff + 1'b1;
         if (!blank_match) begin
            recent_nx[2] = recent_ff[1];
            recent_nx[1] = recent_ff[0];
            recent_nx[0] = data_byte;
            if (fill_ff != 2'd3) fill_nx = fill_ff + 2'd1;
         end
      end
      if ((phase_ff == PH_BODY) && !(&bcnt_ff)) begin
         bcnt_nx = bcnt_ff + 1'b1;
      end
   end

   // reported lengths clamp to sixteen bits
   generate
      if (LENGTH_BITS > 16) begin : g_clamp
         assign hlen16 = (|hcnt_nx[LENGTH_BITS-1:16]) ? FIELD_MAX : hcnt_nx[15:0];
         assign blen16 = (|bcnt_nx[LENGTH_BITS-1:16]) ? FIELD_MAX : bcnt_nx[15:0];
      end else begin : g_extend
         assign hlen16 = 16'(hcnt_nx);
         assign blen16 = 16'(bcnt_nx);
      end
   endgenerate

   // result for the current byte
   always_comb begin
      found                  = final_byte && (phase_nx == PH_BODY);
      result.end_of_response = final_byte;
      result.boundary_found  = found;
      result.status_value    = final_byte ? status_nx : 16'd0;
      result.header_length   = found ? hlen16 : 16'd0;
      result.body_length     = found ? blen16 : 16'd0;
      unique case (phase_ff)
         PH_HEAD, PH_HALT_HEAD: result.region = REGION_HEADER;
         PH_BODY:               result.region = REGION_BODY;
         default:               result.region = REGION_STATUS;
      endcase
   end

   // state load, back to reset values after the final byte
   always_comb begin
      phase_in     = phase_ff;
      status_in    = status_ff;
      hcnt_in      = hcnt_ff;
      bcnt_in      = bcnt_ff;
      recent_in[0] = recent_ff[0];
      recent_in[1] = recent_ff[1];
      recent_in[2] = recent_ff[2];
      fill_in      = fill_ff;
      if (step_en) begin
         if (final_byte) begin
            phase_in  = PH_VERSION;
            status_in = 16'd0;
            hcnt_in   = '0;
            bcnt_in   = '0;
            fill_in   = 2'd0;
         end else begin
            phase_in     = phase_nx;
            status_in    = status_nx;
            hcnt_in      = hcnt_nx;
            bcnt_in      = bcnt_nx;
            recent_in[0] = recent_nx[0];
            recent_in[1] = recent_nx[1];
            recent_in[2] = recent_nx[2];
            fill_in      = fill_nx;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_VERSION;
         status_ff <= 16'd0;
         hcnt_ff   <= '0;
         bcnt_ff   <= '0;
         fill_ff   <= 2'd0;
      end else begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         hcnt_ff   <= hcnt_in;
         bcnt_ff   <= bcnt_in;
         fill_ff   <= fill_in;
      end
   end

   // byte window, guarded by the fill count
   always_ff @(posedge clock) begin
      recent_ff[0] <= recent_in[0];
      recent_ff[1] <= recent_in[1];
      recent_ff[2] <= recent_in[2];
   end

   // checks
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      step_en && final_byte |=> (phase_ff == PH_VERSION) && (status_ff == 16'd0))
      else $error("parser did not restart after final byte");

   a_body_sticks: assert property (@(posedge clock) disable iff (reset)
      step_en && !final_byte && (phase_ff == PH_BODY) |=> (phase_ff == PH_BODY))
      else $error("body phase left before final byte");

   a_found_needs_end: assert property (@(posedge clock) disable iff (reset)
      result.boundary_found |-> result.end_of_response)
      else $error("boundary reported on a non-final byte");

   a_no_body_count_early: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VERSION) |-> (bcnt_ff == '0) && (hcnt_ff == '0))
      else $error("length counters not clear at start of response");

endmodule : hrhp_core

`default_nettype wire

@@ design/http_response_head_parser.sv @@
// ----------------------------------------------------------------------------
// http_response_head_parser: status code and header boundary parser
// Tags every byte of an HTTP response and reports the head summary on the
// last byte.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one response byte per transfer in req_tdata, req_tlast set
//   on the last byte of the response.
//   rsp channel: one transfer per input byte. rsp_tuser carries the byte
//   region and the boundary flag; rsp_tlast marks the result of the last
//   byte, and only that result carries status code, header length and body
//   length in rsp_tdata (zero otherwise).
//   A result passes from the input register through the parsing step into
//   the result register, and is offered once it is registered there.
//   Throughput: one byte per cycle while rsp_tready does not hold the
//   result register.
//   A byte is taken whenever the input register is empty or its byte moves
//   into the result register in the same cycle.
//   Reset empties both registers and clears the parser state; the first byte after
//   reset starts a new response. After each last byte the parser returns to
//   its reset state by itself.
//   While rsp_tready is low the result holds, the input register fills and
//   req_tready drops; no byte or result is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module http_response_head_parser #(
   parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   // request side
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] data_byte
   input  wire         req_tlast,   // final_byte
   // response side
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] status_value, [31:16] header_length,
                                    // [47:32] body_length
   output logic [2:0]  rsp_tuser,   // [1:0] region, [2] boundary_found
   output logic        rsp_tlast    // end_of_response
);
   import hrhp_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff,  in_byte_in;
   logic       in_last_ff,  in_last_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff,   out_res_in;
   result_type step_res;
   logic       out_free;
   logic       step_en;

   // pipeline flow
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step_en    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_last_in  = in_last_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_byte_in  = req_tdata;
         in_last_in  = req_tlast;
      end
   end

   // parsing step
   hrhp_core #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .data_byte  (in_byte_ff),
      .final_byte (in_last_ff),
      .result     (step_res)
   );

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
      if (step_en) begin
         out_res_in = step_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      out_res_ff <= out_res_in;
   end

   // response fields
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_res_ff.body_length, out_res_ff.header_length,
                        out_res_ff.status_value};
   assign rsp_tuser  = {out_res_ff.boundary_found, out_res_ff.region};
   assign rsp_tlast  = out_res_ff.end_of_response;

endmodule : http_response_head_parser

`default_nettype wire
